[hw/rtl/bspid_pkg.sv]
// Shared types, constants and the control program of the steering PID sequencer.
// Used by battery_scaled_pid_with_yaw_trim; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bspid_pkg;

    // Program counter width and fixed entry points of the control program.
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] PC_ERR  = UPC_W'(0);
    localparam logic [UPC_W-1:0] PC_SUM  = UPC_W'(4);
    localparam logic [UPC_W-1:0] PC_EMIT = UPC_W'(12);
    localparam logic [UPC_W-1:0] PC_TICK = UPC_W'(13);

    // Reciprocals for division by five (inputs below 2^31, shift 34)
    // and by twenty-five (inputs below 2^31, shift 36).
    localparam logic [31:0] DIV5_RECIP  = 32'd3435973837;
    localparam logic [31:0] DIV25_RECIP = 32'd2748779070;

    // Heading limits in centidegrees.
    localparam logic signed [15:0] SHARP_LIMIT = 16'sd300;
    localparam logic signed [17:0] WRAP_HALF   = 18'sd18000;
    localparam logic signed [17:0] WRAP_FULL   = 18'sd36000;
    localparam logic signed [17:0] S16_MAX     = 18'sd32767;
    localparam logic signed [17:0] S16_MIN     = -18'sd32768;

    // Base speeds.
    localparam logic [7:0] SPEED_SLOW = 8'd120;
    localparam logic [7:0] SPEED_FAST = 8'd150;

    // Register reset values.
    localparam logic [15:0] FACTOR_RESET   = 16'd3654;
    localparam logic [9:0]  INTERVAL_RESET = 10'd100;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_KP,
        REG_KI,
        REG_KD,
        REG_TARGET,
        REG_FACTOR,
        REG_INTERVAL
    } t_reg_idx;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_KP_E,
        MUL_P_M5,
        MUL_KI_SUM,
        MUL_KD_DERIV,
        MUL_CNT_FAC,
        MUL_HI_VF,
        MUL_LO_VF,
        MUL_DH_M25
    } t_mul_sel;

    // Datapath operation of one step.
    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_ERR_UPD,
        ALU_P_LOAD,
        ALU_DIV5_FIX,
        ALU_ACC_P,
        ALU_ACC_ADD,
        ALU_SMAG,
        ALU_ACC_HI,
        ALU_ACC_LO,
        ALU_TRIM,
        ALU_TICK,
        ALU_EMIT
    } t_alu_op;

    // Sequencing of the step counter.
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF_CALM,
        JMP_DONE
    } t_jump;

    typedef struct packed {
        t_mul_sel         mul;
        t_alu_op          alu;
        t_jump            jump;
        logic [UPC_W-1:0] target;
    } t_uword;

    // Control program. A compute word starts at PC_ERR, a tick at PC_TICK.
    function automatic t_uword ucode_rom(input logic [UPC_W-1:0] addr);
        t_uword w;
        begin
            w = '{mul: MUL_NONE, alu: ALU_EMIT, jump: JMP_DONE, target: PC_EMIT};
            case (addr)
                4'd0:  w = '{MUL_KP_E,     ALU_ERR_UPD,  JMP_NEXT,    PC_EMIT};
                4'd1:  w = '{MUL_NONE,     ALU_P_LOAD,   JMP_IF_CALM, PC_SUM};
                4'd2:  w = '{MUL_P_M5,     ALU_NOP,      JMP_NEXT,    PC_EMIT};
                4'd3:  w = '{MUL_NONE,     ALU_DIV5_FIX, JMP_NEXT,    PC_EMIT};
                4'd4:  w = '{MUL_KI_SUM,   ALU_ACC_P,    JMP_NEXT,    PC_EMIT};
                4'd5:  w = '{MUL_KD_DERIV, ALU_ACC_ADD,  JMP_NEXT,    PC_EMIT};
                4'd6:  w = '{MUL_CNT_FAC,  ALU_ACC_ADD,  JMP_NEXT,    PC_EMIT};
                4'd7:  w = '{MUL_NONE,     ALU_SMAG,     JMP_NEXT,    PC_EMIT};
                4'd8:  w = '{MUL_HI_VF,    ALU_NOP,      JMP_NEXT,    PC_EMIT};
                4'd9:  w = '{MUL_LO_VF,    ALU_ACC_HI,   JMP_NEXT,    PC_EMIT};
                4'd10: w = '{MUL_DH_M25,   ALU_ACC_LO,   JMP_NEXT,    PC_EMIT};
                4'd11: w = '{MUL_NONE,     ALU_TRIM,     JMP_NEXT,    PC_EMIT};
                4'd12: w = '{MUL_NONE,     ALU_EMIT,     JMP_DONE,    PC_EMIT};
                4'd13: w = '{MUL_NONE,     ALU_TICK,     JMP_ALWAYS,  PC_EMIT};
                default: w = '{MUL_NONE,   ALU_EMIT,     JMP_DONE,    PC_EMIT};
            endcase
            return w;
        end
    endfunction

    // Integer part of 3*b/5 for a remainder b of 0..4.
    function automatic logic [1:0] div5_frac(input logic [2:0] rem);
        logic [1:0] f;
        begin
            case (rem)
                3'd2, 3'd3: f = 2'd1;
                3'd4:       f = 2'd2;
                default:    f = 2'd0;
            endcase
            return f;
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/battery_scaled_pid_with_yaw_trim.sv]
// Battery-scaled PID steering controller with yaw trim: top level; depends on bspid_pkg.
// A tick word runs the tick step and the emit step; a compute word runs the PID steps,
// with the divide-by-five cut added on a sharp turn. A new word is taken the cycle after
// a result is emitted; emission waits while the result register is full and not taken.
// The control program steps one shared 33x33 multiplier through its products.
// Synchronous active-low reset restores register defaults and clears all PID state.
`timescale 1ns / 1ps
`default_nettype none

module battery_scaled_pid_with_yaw_trim
    import bspid_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input word channel.
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_operation,
    input  wire logic signed [15:0] i_line_error,
    input  wire logic signed [15:0] i_heading_now,
    input  wire logic        [11:0] i_battery_count,
    // Result word channel.
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed      [15:0] o_correction,
    output logic             [7:0]  o_base_speed,
    output logic signed      [15:0] o_yaw_change,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [4:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);

    // Configuration registers.
    logic        [15:0] r_kp;
    logic        [15:0] r_ki;
    logic        [15:0] r_kd;
    logic signed [15:0] r_target;
    logic        [15:0] r_factor;
    logic        [9:0]  r_interval;

    // Controller state.
    logic signed [31:0] r_error_sum;
    logic signed [15:0] r_prev_error;
    logic signed [15:0] r_prev_heading;
    logic signed [15:0] r_heading_change;
    logic        [9:0]  r_ms_count;

    // Sequencer.
    logic               r_busy, n_busy;
    logic [UPC_W-1:0]   r_pc, n_pc;
    t_uword             uw;
    logic               in_fire, stall, emit_fire, calm;

    // Latched input word and datapath registers.
    logic signed [15:0] r_err;
    logic signed [15:0] r_now;
    logic        [11:0] r_count;
    logic signed [16:0] r_deriv;
    logic signed [32:0] r_p;
    logic signed [65:0] r_prod;
    logic signed [63:0] r_acc;
    logic               r_sneg;
    logic        [49:0] r_smag;
    logic        [27:0] r_vf;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic signed [15:0] r_corr;
    logic        [7:0]  r_speed;
    logic signed [15:0] r_yaw;

    // Configuration writes and reads; the port never waits.
    t_reg_idx cfg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= '0;
            r_ki       <= '0;
            r_kd       <= '0;
            r_target   <= '0;
            r_factor   <= FACTOR_RESET;
            r_interval <= INTERVAL_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_KP:       r_kp       <= pwdata[15:0];
                REG_KI:       r_ki       <= pwdata[15:0];
                REG_KD:       r_kd       <= pwdata[15:0];
                REG_TARGET:   r_target   <= pwdata[15:0];
                REG_FACTOR:   r_factor   <= pwdata[15:0];
                REG_INTERVAL: r_interval <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_KP:       prdata = {16'd0, r_kp};
            REG_KI:       prdata = {16'd0, r_ki};
            REG_KD:       prdata = {16'd0, r_kd};
            REG_TARGET:   prdata = {{16{r_target[15]}}, r_target};
            REG_FACTOR:   prdata = {16'd0, r_factor};
            REG_INTERVAL: prdata = {22'd0, r_interval};
            default:      prdata = '0;
        endcase
    end

    // Handshake and step control.
    assign uw        = ucode_rom(r_pc);
    assign o_ready   = !r_busy;
    assign in_fire   = i_valid && o_ready;
    assign stall     = r_busy && (uw.alu == ALU_EMIT) && r_out_valid && !i_ready;
    assign emit_fire = r_busy && (uw.alu == ALU_EMIT) && !stall;
    assign calm      = (r_heading_change <= SHARP_LIMIT) && (r_heading_change >= -SHARP_LIMIT);

    // Next step of the program.
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (in_fire) begin
            n_busy = 1'b1;
            n_pc   = i_operation ? PC_ERR : PC_TICK;
        end else if (r_busy && !stall) begin
            unique case (uw.jump)
                JMP_NEXT:    n_pc = r_pc + UPC_W'(1);
                JMP_ALWAYS:  n_pc = uw.target;
                JMP_IF_CALM: n_pc = calm ? uw.target : r_pc + UPC_W'(1);
                JMP_DONE:    n_busy = 1'b0;
                default:     n_busy = 1'b0;
            endcase
        end
    end

    // Result register is free when empty or when its word is being taken.
    always_comb begin
        if (emit_fire) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= PC_EMIT;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // Helper values for the datapath steps.
    logic signed [16:0] dh;
    logic        [16:0] dh_abs;
    logic signed [32:0] p_abs;
    logic        [29:0] q5;
    logic        [32:0] five_q;
    logic        [2:0]  rem5;
    logic        [31:0] three_q;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic signed [63:0] acc_abs;
    logic signed [63:0] scaled;
    logic signed [63:0] trim;
    logic        [10:0] ms_next;
    logic signed [17:0] yaw_d, yaw_w1, yaw_w2;
    logic signed [15:0] yaw_sat;
    logic        [47:0] tmag;
    logic signed [15:0] corr_sat;

    always_comb begin
        // Heading error for the trim term.
        dh     = {r_target[15], r_target} - {r_now[15], r_now};
        dh_abs = dh[16] ? 17'(-dh) : 17'(dh);

        // Sharp-turn cut: 3*|p|/5 as 3a + floor(3b/5) with |p| = 5a + b.
        p_abs   = r_p[32] ? -r_p : r_p;
        q5      = r_prod[63:34];
        five_q  = {1'b0, q5, 2'b00} + {3'b000, q5};
        rem5    = p_abs[2:0] - five_q[2:0];
        three_q = {1'b0, q5, 1'b0} + {2'b00, q5} + {30'd0, div5_frac(rem5)};

        // Integral with 32-bit saturation.
        sum_wide = {r_error_sum[31], r_error_sum} + {{17{r_err[15]}}, r_err};
        if (sum_wide[32] != sum_wide[31]) begin
            sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sum_sat = sum_wide[31:0];
        end

        // Magnitude of the accumulator, and the signed sum of scaled PID and trim.
        acc_abs = r_acc[63] ? -r_acc : r_acc;
        scaled  = r_sneg ? -r_acc : r_acc;
        trim    = dh[16] ? -{37'd0, r_prod[62:36]} : {37'd0, r_prod[62:36]};

        // Yaw sampling with wrap into half a turn and 16-bit saturation.
        ms_next = {1'b0, r_ms_count} + 11'd1;
        yaw_d   = {{2{r_now[15]}}, r_now} - {{2{r_prev_heading[15]}}, r_prev_heading};
        yaw_w1  = (yaw_d > WRAP_HALF) ? yaw_d - WRAP_FULL : yaw_d;
        yaw_w2  = (yaw_w1 < -WRAP_HALF) ? yaw_w1 + WRAP_FULL : yaw_w1;
        if (yaw_w2 > S16_MAX) begin
            yaw_sat = 16'sh7FFF;
        end else if (yaw_w2 < S16_MIN) begin
            yaw_sat = 16'sh8000;
        end else begin
            yaw_sat = yaw_w2[15:0];
        end

        // Final correction: drop the fraction toward zero and saturate.
        tmag = acc_abs[63:16];
        if (r_acc[63]) begin
            corr_sat = (tmag > 48'd32768) ? 16'sh8000 : 16'(-tmag[15:0]);
        end else begin
            corr_sat = (tmag > 48'd32767) ? 16'sh7FFF : tmag[15:0];
        end
    end

    // Shared multiplier with operand selection from the control word.
    logic signed [32:0] mul_a, mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (uw.mul)
            MUL_KP_E: begin
                mul_a = {17'd0, r_kp};
                mul_b = {{17{r_err[15]}}, r_err};
            end
            MUL_P_M5: begin
                mul_a = {2'b00, p_abs[30:0]};
                mul_b = {1'b0, DIV5_RECIP};
            end
            MUL_KI_SUM: begin
                mul_a = {17'd0, r_ki};
                mul_b = {r_error_sum[31], r_error_sum};
            end
            MUL_KD_DERIV: begin
                mul_a = {17'd0, r_kd};
                mul_b = {{16{r_deriv[16]}}, r_deriv};
            end
            MUL_CNT_FAC: begin
                mul_a = {21'd0, r_count};
                mul_b = {17'd0, r_factor};
            end
            MUL_HI_VF: begin
                mul_a = {7'd0, r_smag[49:24]};
                mul_b = {5'd0, r_vf};
            end
            MUL_LO_VF: begin
                mul_a = {9'd0, r_smag[23:0]};
                mul_b = {5'd0, r_vf};
            end
            MUL_DH_M25: begin
                mul_a = {2'b00, dh_abs[15:0], 15'd0};
                mul_b = {1'b0, DIV25_RECIP};
            end
            default: ;
        endcase
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        if (r_busy && (uw.mul != MUL_NONE)) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // Input word latch.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_err   <= i_line_error;
            r_now   <= i_heading_now;
            r_count <= i_battery_count;
        end
    end

    // Datapath steps that touch only working registers.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            case (uw.alu)
                ALU_ERR_UPD:  r_deriv <= {r_err[15], r_err} - {r_prev_error[15], r_prev_error};
                ALU_P_LOAD:   r_p <= r_prod[32:0];
                ALU_DIV5_FIX: r_p <= r_p[32] ? -{1'b0, three_q} : {1'b0, three_q};
                ALU_ACC_P:    r_acc <= {{31{r_p[32]}}, r_p};
                ALU_ACC_ADD:  r_acc <= r_acc + r_prod[63:0];
                ALU_SMAG: begin
                    r_sneg <= r_acc[63];
                    r_smag <= acc_abs[49:0];
                    r_vf   <= r_prod[27:0];
                end
                ALU_ACC_HI:   r_acc <= r_prod[63:0];
                ALU_ACC_LO:   r_acc <= r_acc + {24'd0, r_prod[63:24]};
                ALU_TRIM:     r_acc <= scaled + trim;
                ALU_TICK:     r_acc <= '0;
                default: ;
            endcase
        end
    end

    // Controller state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum      <= '0;
            r_prev_error     <= '0;
            r_prev_heading   <= '0;
            r_heading_change <= '0;
            r_ms_count       <= '0;
        end else if (r_busy) begin
            if (uw.alu == ALU_ERR_UPD) begin
                r_error_sum  <= sum_sat;
                r_prev_error <= r_err;
            end
            if (uw.alu == ALU_TICK) begin
                if (ms_next >= {1'b0, r_interval}) begin
                    r_heading_change <= yaw_sat;
                    r_prev_heading   <= r_now;
                    r_ms_count       <= '0;
                end else begin
                    r_ms_count <= ms_next[9:0];
                end
            end
        end
    end

    // Result word register; every field is held until the word is taken.
    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_corr  <= corr_sat;
            r_speed <= calm ? SPEED_FAST : SPEED_SLOW;
            r_yaw   <= r_heading_change;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_correction = r_corr;
    assign o_yaw_change = r_yaw;
    assign o_base_speed = r_speed;

endmodule

`default_nettype wire
